@@ sv/boi_pkg.sv @@
// Package for the bucket order ideal successor block.
// Holds the configuration register indexes and the index width.
`timescale 1ns / 1ps

package boi_pkg;

    typedef enum logic [1:0] {
        REG_FRONT_MASKS = 2'd0,
        REG_TUPLE_SIZE  = 2'd1,
        REG_TUPLE_COUNT = 2'd2,
        REG_VAR_COUNT   = 2'd3
    } cfg_reg_t;

    localparam int CFG_INDEX_W = 2;

endpackage

@@ sv/boi_pipe_stage.sv @@
// One register stage with valid bit and stall control.
// Depends on nothing; payload width is a parameter.
`timescale 1ns / 1ps

module boi_pipe_stage #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    logic             valid_reg;
    logic [WIDTH-1:0] data_reg;

    // accept when empty or when the held word leaves this cycle
    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= in_data;
        end
    end

endmodule

@@ sv/bucket_order_ideal_successor.sv @@
// Top level of the bucket order ideal successor block.
// Depends on boi_pkg and boi_pipe_stage.
`timescale 1ns / 1ps

// Returns the next ideal of a bucket partial order in odometer order. The
// rate is one word per cycle while the output side does not stall. Stage 1
// masks the input and marks each tuple as full or front-full; stage 2 picks
// the lowest non-full tuple and builds the counted mask and the clear base;
// stage 3 does the MAX_VARS-bit compressed increment and detects wrap.
// Stalls from the output side back up through the stages with nothing lost.
// The user must write configuration through its own port only while the
// block holds no word in flight; the block itself does not enforce this.
module bucket_order_ideal_successor
    import boi_pkg::*;
#(
    parameter int MAX_VARS       = 64,
    parameter int MAX_TUPLE_SIZE = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [63:0]            cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [MAX_VARS-1:0]    current_set,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [MAX_VARS-1:0]    next_set,
    output logic                   wrapped
);

    localparam int VW = MAX_VARS;
    localparam int MAXT = MAX_VARS;          // at most one tuple per variable
    localparam int TSW = $clog2(MAX_TUPLE_SIZE + 1);
    localparam int VCW = $clog2(MAX_VARS + 1);

    // ceil(4096 / s) for s of 1 to 32: quotient n / s is (n * recip) >> 12, exact for n < 128
    function automatic logic [12:0] tuple_recip(input logic [5:0] s);
        logic [12:0] r;
        unique case (s)
            6'd2:    r = 13'd2048;
            6'd3:    r = 13'd1366;
            6'd4:    r = 13'd1024;
            6'd5:    r = 13'd820;
            6'd6:    r = 13'd683;
            6'd7:    r = 13'd586;
            6'd8:    r = 13'd512;
            6'd9:    r = 13'd456;
            6'd10:   r = 13'd410;
            6'd11:   r = 13'd373;
            6'd12:   r = 13'd342;
            6'd13:   r = 13'd316;
            6'd14:   r = 13'd293;
            6'd15:   r = 13'd274;
            6'd16:   r = 13'd256;
            6'd17:   r = 13'd241;
            6'd18:   r = 13'd228;
            6'd19:   r = 13'd216;
            6'd20:   r = 13'd205;
            6'd21:   r = 13'd196;
            6'd22:   r = 13'd187;
            6'd23:   r = 13'd179;
            6'd24:   r = 13'd171;
            6'd25:   r = 13'd164;
            6'd26:   r = 13'd158;
            6'd27:   r = 13'd152;
            6'd28:   r = 13'd147;
            6'd29:   r = 13'd142;
            6'd30:   r = 13'd137;
            6'd31:   r = 13'd133;
            6'd32:   r = 13'd128;
            default: r = 13'd4096;
        endcase
        return r;
    endfunction

    logic [63:0] front_masks_reg;
    logic [4:0]  tuple_size_reg;
    logic [5:0]  tuple_count_reg;
    logic [6:0]  var_count_reg;

    assign cfg_ready = 1'b1;

    // hold configuration; write by index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_masks_reg <= '0;
            tuple_size_reg  <= 5'd2;
            tuple_count_reg <= '0;
            var_count_reg   <= 7'd64;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_FRONT_MASKS: front_masks_reg <= cfg_data;
                REG_TUPLE_SIZE:  tuple_size_reg  <= cfg_data[4:0];
                REG_TUPLE_COUNT: tuple_count_reg <= cfg_data[5:0];
                REG_VAR_COUNT:   var_count_reg   <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // saturate configuration (the user must keep it static while words are in flight; not enforced)
    logic [TSW-1:0] ts;
    logic [VCW-1:0] vc;
    logic [6:0]     tc;
    logic [VW-1:0]  vmask;
    logic [VW-1:0]  front_v;
    logic [12:0]    ts_recip;

    always_comb
    begin
        logic [6:0]  tmax;
        logic [19:0] prod;
        if (tuple_size_reg == 5'd0)
            ts = TSW'(1);
        else if (32'(tuple_size_reg) > MAX_TUPLE_SIZE)
            ts = TSW'(MAX_TUPLE_SIZE);
        else
            ts = TSW'(tuple_size_reg);
        if (var_count_reg == 7'd0)
            vc = VCW'(1);
        else if (32'(var_count_reg) > MAX_VARS)
            vc = VCW'(MAX_VARS);
        else
            vc = VCW'(var_count_reg);
        ts_recip = tuple_recip(6'(ts));
        prod = 20'(vc) * 20'(ts_recip);
        tmax = prod[18:12];
        tc = (7'(tuple_count_reg) > tmax) ? tmax : 7'(tuple_count_reg);
        for (int b = 0; b < VW; b++)
        begin
            vmask[b]   = (b < 32'(vc));
            front_v[b] = front_masks_reg[b % 64];
        end
    end

    // per-bit tuple index and ownership, a function of config only
    logic [VW-1:0] in_tuple;
    logic [6:0]    tidx [VW];
    always_comb
    begin
        logic [19:0] bprod;
        for (int b = 0; b < VW; b++)
        begin
            bprod       = 20'(b) * 20'(ts_recip);
            tidx[b]     = bprod[18:12];
            in_tuple[b] = (32'(tidx[b]) < 32'(tc)) && vmask[b];
        end
    end

    // ---------------- stage 1: mask input, per-tuple flags
    typedef struct packed {
        logic [VW-1:0]   cur;
        logic [MAXT-1:0] full;
        logic [MAXT-1:0] ffull;
    } s1_t;

    s1_t s1_d, s1_q;
    logic s1_valid, s1_ready;

    always_comb
    begin
        s1_d.cur = current_set & vmask;
        s1_d.full  = '1;
        s1_d.ffull = '1;
        for (int b = 0; b < VW; b++)
        begin
            if (in_tuple[b])
            begin
                if (!s1_d.cur[b])
                    s1_d.full[tidx[b][$clog2(MAXT)-1:0]] = 1'b0;
                if (!s1_d.cur[b] && front_v[b])
                    s1_d.ffull[tidx[b][$clog2(MAXT)-1:0]] = 1'b0;
            end
        end
    end

    boi_pipe_stage #(.WIDTH($bits(s1_t))) u_s1 (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(s1_d),
        .out_valid(s1_valid), .out_ready(s1_ready), .out_data(s1_q)
    );

    // ---------------- stage 2: pick lowest non-full tuple
    typedef struct packed {
        logic [VW-1:0] cur;
        logic [VW-1:0] cnt;
        logic [VW-1:0] keep;   // bits at or above base
        logic          found;
    } s2_t;

    s2_t s2_d, s2_q;
    logic s2_valid, s2_ready;

    always_comb
    begin
        logic [MAXT-1:0] nf;
        logic [MAXT-1:0] sel;
        logic [MAXT-1:0] below;
        nf = ~s1_q.full;
        sel = nf & (~nf + MAXT'(1));   // lowest set bit
        below = sel - MAXT'(1);
        s2_d.cur   = s1_q.cur;
        s2_d.found = |nf;
        for (int b = 0; b < VW; b++)
        begin
            logic [$clog2(MAXT)-1:0] t;
            t = tidx[b][$clog2(MAXT)-1:0];
            if (s2_d.found)
            begin
                s2_d.keep[b] = !(in_tuple[b] && below[t]);
                s2_d.cnt[b]  = in_tuple[b] && sel[t] &&
                               (s1_q.ffull[t] ? !front_v[b] : front_v[b]);
            end
            else
            begin
                s2_d.keep[b] = !in_tuple[b];
                s2_d.cnt[b]  = vmask[b] && !in_tuple[b];
            end
        end
    end

    boi_pipe_stage #(.WIDTH($bits(s2_t))) u_s2 (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s1_valid), .in_ready(s1_ready), .in_data(s2_d),
        .out_valid(s2_valid), .out_ready(s2_ready), .out_data(s2_q)
    );

    // ---------------- stage 3: compressed increment and wrap
    typedef struct packed {
        logic [VW-1:0] nxt;
        logic          wrap;
    } s3_t;

    s3_t s3_d, s3_q;

    always_comb
    begin
        logic [VW-1:0] base_v;
        logic [VW-1:0] inc;
        base_v = s2_q.cur & s2_q.keep;
        inc = (s2_q.cur | ~s2_q.cnt) + VW'(1);
        s3_d.wrap = !s2_q.found && ((s2_q.cur & s2_q.cnt) == s2_q.cnt);
        if (s3_d.wrap)
            s3_d.nxt = '0;
        else
            s3_d.nxt = ((base_v & ~s2_q.cnt) | (inc & s2_q.cnt)) & vmask;
    end

    boi_pipe_stage #(.WIDTH($bits(s3_t))) u_s3 (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s2_valid), .in_ready(s2_ready), .in_data(s3_d),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(s3_q)
    );

    assign next_set = s3_q.nxt;
    assign wrapped  = s3_q.wrap;

`ifndef ASSERT_OFF
    a_wrap_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && wrapped |-> next_set == '0)
        else $error("wrap with nonzero set");
    a_bits_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (next_set & ~vmask) == '0)
        else $error("bits above var_count");
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(next_set))
        else $error("result lost under stall");
`endif

endmodule
